// ===== sv/mhpq_pkg.sv =====
package mhpq_pkg;

  // Heap geometry
  localparam int unsigned CAPACITY = 32;
  localparam int unsigned AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW       = $clog2(CAPACITY + 1);

  // Payload widths
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned HELD_W   = 6;

  typedef logic signed [VALUE_W-1:0] value_t;

  // Action codes
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

endpackage

// ===== sv/mhpq_if.sv =====
interface mhpq_in_if import mhpq_pkg::*;;
  logic   valid;
  logic   ready;
  logic   action;
  value_t value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

interface mhpq_out_if import mhpq_pkg::*;;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  value_t              removed_value;
  logic [HELD_W-1:0]   entries_held;

  modport source (output valid, output status, output removed_value, output entries_held,
                  input ready);
  modport sink   (input valid, input status, input removed_value, input entries_held,
                  output ready);
endinterface

// ===== sv/mhpq_ram.sv =====
module mhpq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== sv/mhpq_cmp.sv =====
// Shared signed (two's complement) compare used by every sift step.
module mhpq_cmp import mhpq_pkg::*; (
  input  value_t a_i,
  input  value_t b_i,
  output logic   gt_o
);

  assign gt_o = (a_i > b_i);

endmodule

// ===== sv/max_heap_priority_queue.sv =====
// Channel  Dir  Modport      Payload
// in_i     in   mhpq_in_if   action (0 insert, 1 remove max), value (signed 32)
// out_o    out  mhpq_out_if  status, removed_value (signed 32), entries_held (6)
//
// Sequence: insert opens a hole at the new last position and climbs, a parent
//   read and compare per level; remove reads the root and the last entry, then
//   descends, reading the children and comparing per level; errors go straight
//   to the result. One item at a time.
// The heap RAM (one write, one registered read port) and one shared comparator
//   set the pace: every level is one or two reads, one or two compares, and a write.
// Reset clears the sequencer, entry count and result valid; RAM is not cleared,
//   only data at positions below the count is ever used.
// in_i.ready is high only while idle; a finished result waits in the output
//   register and the sequencer holds until that register is free.
module max_heap_priority_queue import mhpq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  mhpq_in_if.sink    in_i,
  mhpq_out_if.source out_o
);

  // Sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_UP    = 4'd1;  // issue parent read
  localparam logic [3:0] S_UPCMP = 4'd2;  // compare item with parent
  localparam logic [3:0] S_RTOP  = 4'd3;  // root arrives, read last
  localparam logic [3:0] S_RLAST = 4'd4;  // last entry arrives
  localparam logic [3:0] S_DN    = 4'd5;  // issue left child read
  localparam logic [3:0] S_DNL   = 4'd6;  // left arrives
  localparam logic [3:0] S_DNR   = 4'd7;  // right arrives, pick larger
  localparam logic [3:0] S_DNC   = 4'd8;  // compare child with item
  localparam logic [3:0] S_DONE  = 4'd9;  // hand result to output register

  localparam int unsigned LW = AW + 2;  // width of child indexes before range check

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [AW-1:0] cpos_q, cpos_d;
  value_t        hold_q, hold_d;     // item being sifted (hole method)
  value_t        child_q, child_d;
  value_t        top_q, top_d;
  status_e       stat_q, stat_d;

  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  value_t              out_removed_q, out_removed_d;
  logic [HELD_W-1:0]   out_held_q, out_held_d;

  // RAM port
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  value_t        ram_wdata, ram_rdata;

  // Shared comparator
  value_t cmp_a, cmp_b;
  logic   cmp_gt;

  logic          in_fire;
  logic [AW-1:0] pos_m1, parent;
  logic [LW-1:0] left_w, right_w, cnt_w;
  logic          has_left, has_right;
  logic [CW+HELD_W-1:0] held_w;
  logic          out_free;

  mhpq_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  mhpq_cmp u_cmp (
    .a_i  (cmp_a),
    .b_i  (cmp_b),
    .gt_o (cmp_gt)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;

  // Zero-based heap: parent (i-1)/2, children 2i+1 and 2i+2
  assign pos_m1    = pos_q - AW'(1);
  assign parent    = pos_m1 >> 1;
  assign left_w    = {1'b0, pos_q, 1'b0} + LW'(1);
  assign right_w   = left_w + LW'(1);
  assign cnt_w     = LW'(cnt_q);
  assign has_left  = (left_w < cnt_w);
  assign has_right = (right_w < cnt_w);

  assign held_w   = {{HELD_W{1'b0}}, cnt_q};
  assign out_free = !out_valid_q || out_o.ready;

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = out_status_q;
  assign out_o.removed_value = out_removed_q;
  assign out_o.entries_held  = out_held_q;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    pos_d     = pos_q;
    cpos_d    = cpos_q;
    hold_d    = hold_q;
    child_d   = child_q;
    top_d     = top_q;
    stat_d    = stat_q;
    ram_we    = 1'b0;
    ram_waddr = pos_q;
    ram_wdata = hold_q;
    ram_raddr = parent;
    cmp_a     = hold_q;
    cmp_b     = child_q;

    out_valid_d   = out_valid_q && !out_o.ready;
    out_status_d  = out_status_q;
    out_removed_d = out_removed_q;
    out_held_d    = out_held_q;

    unique case (state_q)
      S_IDLE: begin
        ram_raddr = '0;
        if (in_fire) begin
          top_d  = '0;
          stat_d = ST_OK;
          if (in_i.action == ACT_INSERT) begin
            if (cnt_q == CW'(CAPACITY)) begin
              stat_d  = ST_FULL;
              state_d = S_DONE;
            end else begin
              pos_d   = cnt_q[AW-1:0];
              cnt_d   = cnt_q + CW'(1);
              hold_d  = in_i.value;
              state_d = S_UP;
            end
          end else begin
            if (cnt_q == '0) begin
              stat_d  = ST_EMPTY;
              state_d = S_DONE;
            end else begin
              // root read issued this cycle
              cnt_d   = cnt_q - CW'(1);
              state_d = S_RTOP;
            end
          end
        end
      end

      S_UP: begin
        if (pos_q == '0) begin
          ram_we  = 1'b1;
          state_d = S_DONE;
        end else begin
          state_d = S_UPCMP;
        end
      end

      S_UPCMP: begin
        cmp_a  = hold_q;
        cmp_b  = ram_rdata;
        ram_we = 1'b1;
        if (cmp_gt) begin
          // parent moves down into the hole
          ram_wdata = ram_rdata;
          pos_d     = parent;
          state_d   = S_UP;
        end else begin
          state_d = S_DONE;
        end
      end

      S_RTOP: begin
        top_d     = ram_rdata;
        ram_raddr = cnt_q[AW-1:0];
        state_d   = S_RLAST;
      end

      S_RLAST: begin
        hold_d  = ram_rdata;
        pos_d   = '0;
        state_d = S_DN;
      end

      S_DN: begin
        ram_raddr = left_w[AW-1:0];
        if (has_left) begin
          state_d = S_DNL;
        end else begin
          ram_we  = 1'b1;
          state_d = S_DONE;
        end
      end

      S_DNL: begin
        ram_raddr = right_w[AW-1:0];
        child_d   = ram_rdata;
        cpos_d    = left_w[AW-1:0];
        state_d   = has_right ? S_DNR : S_DNC;
      end

      S_DNR: begin
        // right wins only when strictly larger
        cmp_a   = ram_rdata;
        cmp_b   = child_q;
        if (cmp_gt) begin
          child_d = ram_rdata;
          cpos_d  = cpos_q + AW'(1);
        end
        state_d = S_DNC;
      end

      S_DNC: begin
        cmp_a  = child_q;
        cmp_b  = hold_q;
        ram_we = 1'b1;
        if (cmp_gt) begin
          ram_wdata = child_q;
          pos_d     = cpos_q;
          state_d   = S_DN;
        end else begin
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          out_status_d  = stat_q;
          out_removed_d = top_q;
          out_held_d    = held_w[HELD_W-1:0];
          state_d       = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q         <= pos_d;
    cpos_q        <= cpos_d;
    hold_q        <= hold_d;
    child_q       <= child_d;
    top_q         <= top_d;
    stat_q        <= stat_d;
    out_status_q  <= out_status_d;
    out_removed_q <= out_removed_d;
    out_held_q    <= out_held_d;
  end

  // Checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_cnt_only_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_fire |=> $stable(cnt_q))
    else $error("entry count moved without an accepted item");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> state_q != S_IDLE)
    else $error("heap write while idle");

  a_empty_remove: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_i.action == ACT_REMOVE && cnt_q == '0 |=>
      state_q == S_DONE && stat_q == ST_EMPTY)
    else $error("remove from empty heap not reported");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_DONE)
    else $error("result raised outside done state");

endmodule

// ===== tb/sv/mhpq_order_checker.sv =====
`timescale 1ns / 100ps

module mhpq_order_checker import mhpq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  mhpq_in_if          in_mon_i,
  mhpq_out_if         out_mon_i,
  output int unsigned mismatch_cnt_o,
  output int unsigned pending_o,
  output int unsigned full_cnt_o,
  output int unsigned empty_cnt_o,
  output int unsigned checked_cnt_o
);

  typedef struct {
    status_e           status;
    value_t            removed_value;
    logic [HELD_W-1:0] entries_held;
  } heap_reply_t;

  // Shadow heap, root at index 1
  value_t      keys [1:CAPACITY];
  int unsigned held;
  heap_reply_t replies_q [$];

  int unsigned n_mismatch;
  int unsigned n_full;
  int unsigned n_empty;
  int unsigned n_checked;

  function automatic heap_reply_t heap_apply(logic act, value_t v);
    heap_reply_t r;
    int unsigned pos;
    int unsigned kid;
    value_t      tmp;
    bit          moving;
    r.status        = ST_OK;
    r.removed_value = '0;
    if (act == ACT_INSERT) begin
      if (held >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        held++;
        keys[held] = v;
        pos = held;
        // climb while the parent is strictly smaller
        while (pos > 1 && keys[pos / 2] < keys[pos]) begin
          tmp            = keys[pos / 2];
          keys[pos / 2]  = keys[pos];
          keys[pos]      = tmp;
          pos            = pos / 2;
        end
      end
    end else begin
      if (held == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.removed_value = keys[1];
        keys[1] = keys[held];
        held--;
        pos    = 1;
        moving = 1'b1;
        // descend toward the larger child, left wins a tie
        while (moving && 2 * pos <= held) begin
          kid = 2 * pos;
          if (kid + 1 <= held && keys[kid + 1] > keys[kid]) kid = kid + 1;
          if (keys[pos] >= keys[kid]) begin
            moving = 1'b0;
          end else begin
            tmp       = keys[pos];
            keys[pos] = keys[kid];
            keys[kid] = tmp;
            pos       = kid;
          end
        end
      end
    end
    r.entries_held = HELD_W'(held);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    heap_reply_t want;
    if (!rst_ni) begin
      held       = 0;
      n_mismatch = 0;
      n_full     = 0;
      n_empty    = 0;
      n_checked  = 0;
      replies_q.delete();
      mismatch_cnt_o <= 0;
      pending_o      <= 0;
      full_cnt_o     <= 0;
      empty_cnt_o    <= 0;
      checked_cnt_o  <= 0;
    end else begin
      // result side first: a result always belongs to an earlier item
      if (out_mon_i.valid && out_mon_i.ready) begin
        n_checked++;
        if (replies_q.size() == 0) begin
          n_mismatch++;
          $display("%0t: result with nothing expected: status %0d removed %0d held %0d",
                   $time, out_mon_i.status, out_mon_i.removed_value, out_mon_i.entries_held);
        end else begin
          want = replies_q.pop_front();
          if (out_mon_i.status !== want.status) begin
            n_mismatch++;
            $display("%0t: status expected %0d actual %0d",
                     $time, want.status, out_mon_i.status);
          end
          if (out_mon_i.removed_value !== want.removed_value) begin
            n_mismatch++;
            $display("%0t: removed_value expected %0d actual %0d",
                     $time, want.removed_value, out_mon_i.removed_value);
          end
          if (out_mon_i.entries_held !== want.entries_held) begin
            n_mismatch++;
            $display("%0t: entries_held expected %0d actual %0d",
                     $time, want.entries_held, out_mon_i.entries_held);
          end
        end
      end
      if (in_mon_i.valid && in_mon_i.ready) begin
        want = heap_apply(in_mon_i.action, in_mon_i.value);
        if (want.status == ST_FULL) n_full++;
        if (want.status == ST_EMPTY) n_empty++;
        replies_q.push_back(want);
      end
      mismatch_cnt_o <= n_mismatch;
      pending_o      <= replies_q.size();
      full_cnt_o     <= n_full;
      empty_cnt_o    <= n_empty;
      checked_cnt_o  <= n_checked;
    end
  end

endmodule

// ===== tb/sv/tb_max_heap_priority_queue.sv =====
`timescale 1ns / 100ps

module tb_max_heap_priority_queue;
  import mhpq_pkg::*;

  // Run shape
  localparam int unsigned ITEMS_TOTAL    = 1350;
  localparam int unsigned STALL_MAX      = 9;
  // Handshake-free stretch after which the watchdog stops the run
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  // Extra wait after the last result, to catch a stray one
  localparam int unsigned TAIL_CYCLES    = 40;

  localparam value_t V_MAX = 32'h7FFF_FFFF;
  localparam value_t V_MIN = 32'h8000_0000;

  // Random part is built from these sequence kinds
  typedef enum int unsigned {
    PH_FILL,   // insert capacity items or more: fills the heap and can reach the full-heap case
    PH_DRAIN,  // remove capacity items or more: empties the heap and can reach the empty-heap case
    PH_MIXED,  // random insert/remove mix with a random bias
    PH_SORT    // k inserts then k removes, a heap sort in miniature
  } phase_e;

  // Value pools: wide random, the signed extremes and values around zero, or a
  // tight band that produces many equal keys
  typedef enum int unsigned {
    VM_WIDE,
    VM_EDGE,
    VM_TIGHT
  } value_mode_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  mhpq_in_if  in_if ();
  mhpq_out_if out_if ();

  int unsigned mismatch_cnt;
  int unsigned pending;
  int unsigned full_cnt;
  int unsigned empty_cnt;
  int unsigned checked_cnt;

  int unsigned n_sent      = 0;
  int unsigned n_insert    = 0;
  int unsigned n_remove    = 0;
  int unsigned idle_cycles = 0;
  bit          calm        = 1'b0;  // when set, neither side idles
  value_mode_e vmode       = VM_WIDE;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  max_heap_priority_queue i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  mhpq_order_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_mon_i       (in_if),
    .out_mon_i      (out_if),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending),
    .full_cnt_o     (full_cnt),
    .empty_cnt_o    (empty_cnt),
    .checked_cnt_o  (checked_cnt)
  );

  // Per-item wait for either side; zero during calm stretches
  function automatic int unsigned draw_wait();
    return calm ? 0 : $urandom_range(0, STALL_MAX);
  endfunction

  function automatic value_t draw_value();
    value_t v;
    case (vmode)
      VM_EDGE: begin
        case ($urandom_range(0, 6))
          0:       v = V_MAX;
          1:       v = V_MIN;
          2:       v = V_MAX - 1;
          3:       v = V_MIN + 1;
          4:       v = '0;
          5:       v = -1;
          default: v = 1;
        endcase
      end
      VM_TIGHT: v = value_t'(int'($urandom_range(0, 6)) - 3);
      default:  v = $urandom();
    endcase
    return v;
  endfunction

  // Present one item after a random gap and hold it until taken.
  // valid stays high on exit so back-to-back items need no extra edge.
  task automatic send_item(logic act, value_t v);
    int unsigned gap;
    gap = draw_wait();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid  <= 1'b1;
    in_if.action <= act;
    in_if.value  <= v;
    do @(posedge clk_i); while (!in_if.ready);
    n_sent++;
    if (act == ACT_INSERT) n_insert++;
    else n_remove++;
  endtask

  // Stop sending until every outstanding result has been taken
  task automatic hold_until_settled();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Result side: random stall per item. Half the stalls start only once a
  // result is showing, so backpressure lands on a waiting result too.
  initial begin : result_sink
    int unsigned gap;
    out_if.ready <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      gap = draw_wait();
      if (gap != 0) begin
        out_if.ready <= 1'b0;
        if ($urandom_range(0, 1) == 1) begin
          do @(posedge clk_i); while (!out_if.valid);
        end
        repeat (gap) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
    end
  end

  // Watchdog: any handshake on either channel resets the count
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                 $time, WATCHDOG_LIMIT, pending);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin : item_source
    int unsigned n;
    int unsigned k;
    int unsigned ins_pct;
    in_if.valid  <= 1'b0;
    in_if.action <= ACT_INSERT;
    in_if.value  <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: remove on an empty heap first
    send_item(ACT_REMOVE, V_MAX);
    // Signed extremes, zero, -1, and a run of equal keys
    send_item(ACT_INSERT, V_MAX);
    send_item(ACT_INSERT, V_MIN);
    send_item(ACT_INSERT, '0);
    send_item(ACT_INSERT, -1);
    send_item(ACT_INSERT, 5);
    send_item(ACT_INSERT, 5);
    send_item(ACT_INSERT, 5);
    send_item(ACT_INSERT, 1);
    // Drain all eight (the last one removes the only entry), then one more
    // on the empty heap; payload on remove is don't-care, so keep it random
    repeat (9) send_item(ACT_REMOVE, $urandom());
    // Lone entry in and out at the bottom of the range
    send_item(ACT_INSERT, V_MIN);
    send_item(ACT_REMOVE, V_MAX);
    // Let everything settle before the random part
    hold_until_settled();

    while (n_sent < ITEMS_TOTAL) begin
      calm  = ($urandom_range(0, 3) == 0);
      vmode = value_mode_e'($urandom_range(0, 2));
      case (phase_e'($urandom_range(0, 3)))
        PH_FILL: begin
          repeat (CAPACITY + $urandom_range(0, 4)) send_item(ACT_INSERT, draw_value());
        end
        PH_DRAIN: begin
          repeat (CAPACITY + $urandom_range(0, 4)) send_item(ACT_REMOVE, $urandom());
        end
        PH_MIXED: begin
          n       = $urandom_range(20, 60);
          ins_pct = $urandom_range(25, 75);
          repeat (n) begin
            if ($urandom_range(0, 99) < ins_pct) send_item(ACT_INSERT, draw_value());
            else send_item(ACT_REMOVE, $urandom());
          end
        end
        default: begin
          k = $urandom_range(1, CAPACITY);
          repeat (k) send_item(ACT_INSERT, draw_value());
          repeat (k) send_item(ACT_REMOVE, $urandom());
        end
      endcase
      // Occasionally go quiet until the queue of results is empty
      if ($urandom_range(0, 5) == 0) hold_until_settled();
    end

    // Wind down: wait for the last results, then wait out the tail
    // so a stray extra result would still be caught
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Covered %0d items: %0d inserts (%0d into a full heap), %0d removes (%0d on empty)",
             n_sent, n_insert, full_cnt, n_remove, empty_cnt);
    $display("%0d results compared, %0d field mismatches", checked_cnt, mismatch_cnt);
    if (mismatch_cnt == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
